[sv/assert_macros.svh]
// Assertion macros used by the block's top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/bbps_pkg.sv]
// Types, constants and helpers of the box bounce particle step
package bbps_pkg;

	localparam int NUM_AXES = 3;
	localparam int AXIS_H   = 2;
	localparam int QBITS    = 33;
	localparam int IN_W     = 248;
	localparam int OUT_W    = 200;

	localparam logic [30:0] WALL_RST    = 31'd1310720;
	localparam logic [30:0] GRAVITY_RST = 31'd642908;
	localparam logic [31:0] ONE_Q16     = 32'd65536;

	typedef enum logic [1:0] {
		REG_WALL_X,
		REG_WALL_Y,
		REG_WALL_Z,
		REG_GRAVITY
	} cfg_reg_t;

	typedef struct packed {
		logic signed [39:0] np;
		logic signed [32:0] nv;
		logic signed [31:0] vel;
		logic               bounce;
		logic               zt;
		logic        [36:0] ad;
		logic        [36:0] ovr;
	} lane_res_t;

	typedef struct packed {
		lane_res_t [NUM_AXES-1:0] ax;
		logic      [30:0]         gd;
		logic                     ovf;
		logic                     adz;
	} dly_t;

	typedef struct packed {
		logic signed [NUM_AXES-1:0][31:0] np;
		logic signed [NUM_AXES-1:0][31:0] nv;
		logic        [NUM_AXES-1:0]       mask;
		logic                             zt;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

[sv/bbps_lane.sv]
// One axis lane: travel product, wall test and reflection
module bbps_lane (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [31:0]       pos,
	input  logic signed [31:0]       vel,
	input  logic        [30:0]       radius,
	input  logic        [19:0]       time_step,
	input  logic        [30:0]       wall,
	output bbps_pkg::lane_res_t      res
);
	import bbps_pkg::*;

	logic signed [52:0] dfull;
	logic signed [31:0] p_s1, v_s1;
	logic        [30:0] r_s1;
	logic signed [36:0] d_s1;
	logic signed [32:0] sr;
	logic signed [38:0] sum;
	logic        [38:0] asum;
	logic        [36:0] ad;
	logic        [31:0] ap;
	logic        [38:0] ov;
	logic        [39:0] io;
	logic signed [39:0] np_b, np_n;
	logic               bounce;
	lane_res_t          res_s2;

	assign dfull = vel * $signed({1'b0, time_step});

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= pos;
			v_s1 <= vel;
			r_s1 <= radius;
			d_s1 <= 37'(dfull >>> 16);
		end
	end

	always_comb begin
		sr     = p_s1[31] ? -$signed({2'b0, r_s1}) : $signed({2'b0, r_s1});
		sum    = 39'(p_s1) + 39'(sr) + 39'(d_s1);
		asum   = sum[38] ? 39'(-sum) : 39'(sum);
		bounce = asum >= {8'b0, wall};
		ad     = d_s1[36] ? 37'(-d_s1) : 37'(d_s1);
		ap     = p_s1[31] ? 32'(-p_s1) : 32'(p_s1);
		ov     = {7'b0, ap} + {8'b0, r_s1} + {2'b0, ad} - {8'b0, wall};
		io     = {3'b0, ad} - {2'b0, ov[36:0], 1'b0};
		np_b   = p_s1[31] ? 40'(p_s1) - $signed(io) : 40'(p_s1) + $signed(io);
		np_n   = 40'(p_s1) + 40'(d_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.np     <= bounce ? np_b : np_n;
			res_s2.nv     <= bounce ? -33'(v_s1) : 33'(v_s1);
			res_s2.vel    <= v_s1;
			res_s2.bounce <= bounce;
			res_s2.zt     <= bounce && (ad == '0);
			res_s2.ad     <= ad;
			res_s2.ovr    <= ov[36:0];
		end
	end

	assign res = res_s2;

endmodule

[sv/bbps_div.sv]
// Pipelined restoring divider, one quotient bit per stage
module bbps_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [36:0]                 num,
	input  logic [36:0]                 den,
	output logic [bbps_pkg::QBITS-1:0]  quo,
	output logic                        rem_nz
);
	import bbps_pkg::*;

	logic [36:0]       rem_s [0:QBITS];
	logic [QBITS-1:0]  lo_s  [0:QBITS];
	logic [QBITS-1:0]  q_s   [0:QBITS];
	logic [36:0]       dv_s  [0:QBITS];

	assign rem_s[0] = {17'b0, num[36:17]};
	assign lo_s[0]  = {num[16:0], 16'b0};
	assign q_s[0]   = '0;
	assign dv_s[0]  = den;

	for (genvar k = 0; k < QBITS; k++) begin : g_stage
		logic [37:0] t;
		logic        ge;
		always_comb begin
			t  = {rem_s[k], lo_s[k][QBITS-1]};
			ge = t >= {1'b0, dv_s[k]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? 37'(t - {1'b0, dv_s[k]}) : t[36:0];
				lo_s[k+1]  <= {lo_s[k][QBITS-2:0], 1'b0};
				q_s[k+1]   <= {q_s[k][QBITS-2:0], ge};
				dv_s[k+1]  <= dv_s[k];
			end
		end
	end

	assign quo    = q_s[QBITS];
	assign rem_nz = rem_s[QBITS] != '0;

endmodule

[sv/bbps_merge.sv]
// Merge stage: height gravity kick, saturation and result assembly
module bbps_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld,
	input  bbps_pkg::dly_t       din,
	input  logic [bbps_pkg::QBITS-1:0] quo,
	input  logic                 rem_nz,
	output logic                 vld_out,
	output bbps_pkg::res_t       res
);
	import bbps_pkg::*;

	logic [QBITS-1:0]   qe;
	logic               adj;
	logic signed [34:0] fin_w;
	logic signed [31:0] fin, fout;
	logic signed [31:0] fin_s1, fout_s1;
	dly_t               d_s1, d_s2;
	logic signed [63:0] pin_s2, pout_s2;
	logic               vld_s1, vld_s2;
	logic signed [63:0] nvz;

	always_comb begin
		qe    = din.ovf ? '1 : quo;
		adj   = rem_nz && (qe < QBITS'(ONE_Q16));
		fin_w = 35'(ONE_Q16) - 35'(qe) - 35'(adj);
		if (din.adz) begin
			fin  = '0;
			fout = ONE_Q16;
		end else begin
			fin  = sat32(64'(fin_w));
			fout = (qe > QBITS'(32'h7fffffff)) ? 32'sh7fffffff : qe[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s1  <= fin;
			fout_s1 <= fout;
			d_s1    <= din;
			pin_s2  <= $signed({1'b0, d_s1.gd}) * fin_s1;
			pout_s2 <= $signed({1'b0, d_s1.gd}) * fout_s1;
			d_s2    <= d_s1;
		end
	end

	always_comb begin
		nvz = (pin_s2 >>> 16) - (pout_s2 >>> 16) - 64'(d_s2.ax[AXIS_H].vel);
		for (int a = 0; a < NUM_AXES; a++) begin
			res.np[a]   = sat32(64'(d_s2.ax[a].np));
			res.nv[a]   = sat32(64'(d_s2.ax[a].nv));
			res.mask[a] = d_s2.ax[a].bounce;
		end
		if (d_s2.ax[AXIS_H].bounce)
			res.nv[AXIS_H] = sat32(nvz);
		res.zt = d_s2.ax[0].zt || d_s2.ax[1].zt || d_s2.ax[2].zt;
	end

	assign vld_out = vld_s2;

endmodule

[sv/box_bounce_particle_step_top.sv]
// Top level of the box bounce particle step
// One item is accepted per clock while the two-entry output buffer is not full. Each
// item passes through two front stages (travel product, wall test), the 33-stage
// quotient pipeline of the height lane and two merge stages (gravity kick product,
// saturation), plus any wait at the output buffer. Three axis lanes run side by side;
// the whole pipeline halts only when the output buffer is full. The user must
// write registers through cfg_we/cfg_idx/cfg_data while idle; no logic enforces it.
`include "assert_macros.svh"
module box_bounce_particle_step_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_idx,
	input  logic [30:0]                  cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius, time_step, zero fill
	input  logic [bbps_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// new_pos_x..z, new_vel_x..z, bounce_mask, zero_travel, zero fill
	output logic [bbps_pkg::OUT_W-1:0]   m_tdata
);
	import bbps_pkg::*;

	logic [30:0]  wall_q [NUM_AXES];
	logic [30:0]  gravity_q;
	logic         en;
	logic         vld_s1, vld_s2;
	logic [50:0]  gfull;
	logic [30:0]  gd_s1, gd_s2;
	lane_res_t    lres [NUM_AXES];
	dly_t         dly_in;
	dly_t         dly_q [0:QBITS-1];
	logic         dvld_q [0:QBITS-1];
	logic [QBITS-1:0] quo;
	logic         rem_nz;
	logic         mvld;
	res_t         mres;
	res_t         buf0_q, buf1_q;
	logic [1:0]   cnt_q;
	logic         push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_q[0] <= WALL_RST;
			wall_q[1] <= WALL_RST;
			wall_q[2] <= WALL_RST;
			gravity_q <= GRAVITY_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WALL_X:  wall_q[0] <= cfg_data;
				REG_WALL_Y:  wall_q[1] <= cfg_data;
				REG_WALL_Z:  wall_q[2] <= cfg_data;
				REG_GRAVITY: gravity_q <= cfg_data;
			endcase
		end
	end

	assign en       = cnt_q != 2'd2;
	assign s_tready = en;

	assign gfull = 51'(gravity_q) * 51'(s_tdata[242:223]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gd_s1 <= (gfull[50:47] != '0) ? 31'h7fffffff : gfull[46:16];
			gd_s2 <= gd_s1;
		end
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		bbps_lane u_lane (
			.clk       (clk),
			.en        (en),
			.pos       (s_tdata[32*a +: 32]),
			.vel       (s_tdata[96 + 32*a +: 32]),
			.radius    (s_tdata[222:192]),
			.time_step (s_tdata[242:223]),
			.wall      (wall_q[a]),
			.res       (lres[a])
		);
	end

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++)
			dly_in.ax[a] = lres[a];
		dly_in.gd  = gd_s2;
		dly_in.adz = lres[AXIS_H].ad == '0;
		dly_in.ovf = {17'b0, lres[AXIS_H].ovr} >= {lres[AXIS_H].ad, 17'b0};
	end

	bbps_div u_div (
		.clk    (clk),
		.en     (en),
		.num    (lres[AXIS_H].ovr),
		.den    (lres[AXIS_H].ad),
		.quo    (quo),
		.rem_nz (rem_nz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QBITS; k++)
				dvld_q[k] <= 1'b0;
		end else if (en) begin
			dvld_q[0] <= vld_s2;
			for (int k = 1; k < QBITS; k++)
				dvld_q[k] <= dvld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= dly_in;
			for (int k = 1; k < QBITS; k++)
				dly_q[k] <= dly_q[k-1];
		end
	end

	bbps_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (dvld_q[QBITS-1]),
		.din     (dly_q[QBITS-1]),
		.quo     (quo),
		.rem_nz  (rem_nz),
		.vld_out (mvld),
		.res     (mres)
	);

	assign push = mvld && en;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: begin
				if (push)
					buf0_q <= mres;
			end
			2'd1: begin
				if (push && pop)
					buf0_q <= mres;
				else if (push)
					buf1_q <= mres;
			end
			default: begin
				if (pop)
					buf0_q <= buf1_q;
			end
		endcase
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = {4'b0, buf0_q.zt, buf0_q.mask,
		buf0_q.nv[2], buf0_q.nv[1], buf0_q.nv[0],
		buf0_q.np[2], buf0_q.np[1], buf0_q.np[0]};

	`ASSERT_ALWAYS(a_cnt_range, cnt_q != 2'd3, "output buffer count out of range")
	`ASSERT_NEXT(a_stall_hold, !en, vld_s2 == $past(vld_s2), "front stage moved while halted")
	`ASSERT_ALWAYS(a_zt_bounce, !m_tvalid || !buf0_q.zt || (buf0_q.mask != '0),
		"zero travel flagged without a bounce")

endmodule

[tb/tb_box_bounce_particle_step_top.sv]
// Self-checking testbench for the box bounce particle step: directed table, then random items
module tb_box_bounce_particle_step_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bbps_pkg::*;

	typedef struct packed {
		logic             zt;
		logic [2:0]       mask;
		logic [2:0][31:0] nv;
		logic [2:0][31:0] np;
	} step_res_t;

	typedef struct packed {
		logic [19:0]      dt;
		logic [30:0]      radius;
		logic [2:0][31:0] vel;
		logic [2:0][31:0] pos;
	} step_in_t;

	typedef struct {
		step_in_t  item;
		bit        typed;
		step_res_t res;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_idx;
	logic [30:0]      cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius, time_step, zero fill
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	// new_pos_x..z, new_vel_x..z, bounce_mask, zero_travel, zero fill
	logic [OUT_W-1:0] m_tdata;

	box_bounce_particle_step_top uut (.*);

	longint    wall_cfg [3];
	longint    gravity_cfg;
	step_res_t step_q [$];
	int        errors = 0;
	int        cycles = 0;
	int        n_in = 0;
	int        n_out = 0;
	int        n_bounce = 0;
	int        n_zero = 0;
	bit        fast_send = 0;
	bit        fast_recv = 0;
	bit        hold_req = 0;
	stim_row_t rows [$];

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("box_bounce_particle_step_top test failed");
			$finish;
		end
	end

	function automatic longint floor_q16(longint x);
		return x >>> 16;
	endfunction

	function automatic longint clamp_q(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint abs_l(longint x);
		return x < 0 ? -x : x;
	endfunction

	function automatic step_res_t predict_step(step_in_t it);
		step_res_t res;
		longint    dt, gd, p, v, r, w, d, sr, ad, ovr, inn, sgn, np, nv, fin, fout;
		dt = longint'(it.dt);
		r = longint'(it.radius);
		gd = (gravity_cfg * dt) >>> 16;
		if (gd > 64'sd2147483647)
			gd = 64'sd2147483647;
		res = '0;
		for (int a = 0; a < 3; a++) begin
			p = longint'($signed(it.pos[a]));
			v = longint'($signed(it.vel[a]));
			w = wall_cfg[a];
			d = floor_q16(v * dt);
			sr = (p < 0) ? -r : r;
			if (abs_l(p + sr + d) < w) begin
				np = p + d;
				nv = v;
			end else begin
				res.mask[a] = 1'b1;
				ad = abs_l(d);
				ovr = abs_l(p) + r + ad - w;
				inn = ad - ovr;
				sgn = (p < 0) ? -1 : 1;
				np = p + sgn * (inn - ovr);
				if (ad == 0)
					res.zt = 1'b1;
				if (a == AXIS_H) begin
					if (ad == 0) begin
						fin = 0;
						fout = 65536;
					end else begin
						fin = clamp_q((inn * 65536) / ad);
						fout = clamp_q((ovr * 65536) / ad);
					end
					nv = -(v - floor_q16(gd * fin) + floor_q16(gd * fout));
				end else begin
					nv = -v;
				end
			end
			res.np[a] = 32'(clamp_q(np));
			res.nv[a] = 32'(clamp_q(nv));
		end
		return res;
	endfunction

	always @(posedge clk) begin
		step_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[195:0];
			if (step_q.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				want = step_q.pop_front();
				for (int a = 0; a < 3; a++) begin
					if (got.np[a] !== want.np[a]) begin
						$error("new_pos[%0d]: expected %h, got %h", a, want.np[a], got.np[a]);
						errors++;
					end
					if (got.nv[a] !== want.nv[a]) begin
						$error("new_vel[%0d]: expected %h, got %h", a, want.nv[a], got.nv[a]);
						errors++;
					end
				end
				if (got.mask !== want.mask) begin
					$error("bounce_mask: expected %h, got %h", want.mask, got.mask);
					errors++;
				end
				if (got.zt !== want.zt) begin
					$error("zero_travel: expected %h, got %h", want.zt, got.zt);
					errors++;
				end
			end
			n_out++;
			if (got.mask != 0)
				n_bounce++;
			if (got.zt)
				n_zero++;
		end
	end

	initial begin
		int stall;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 0;
				for (int c = 0; c < 400; c++)
					@(posedge clk);
				hold_req = 0;
			end else begin
				stall = fast_recv ? 0 : $urandom_range(0, 11);
				if (stall > 0) begin
					m_tready <= 0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1;
			do
				@(negedge clk);
			while (!m_tvalid);
			@(posedge clk);
		end
	end

	task automatic offer_item(step_in_t it, bit typed, step_res_t res);
		int gap;
		gap = fast_send ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		step_q.push_back(typed ? res : predict_step(it));
		s_tdata <= {5'd0, it};
		s_tvalid <= 1;
		do
			@(negedge clk);
		while (!s_tready);
		@(posedge clk);
		n_in++;
	endtask

	task automatic drain;
		s_tvalid <= 0;
		while (step_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [30:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_GRAVITY)
			gravity_cfg = longint'(val);
		else
			wall_cfg[idx] = longint'(val);
	endtask

	function automatic logic [31:0] near_val(longint lim);
		longint v;
		if (lim > 64'sd2147483647)
			lim = 64'sd2147483647;
		v = longint'($urandom_range(0, int'(lim)));
		if ($urandom_range(0, 1))
			v = -v;
		return 32'(v);
	endfunction

	function automatic step_in_t random_item();
		step_in_t it;
		if ($urandom_range(0, 9) == 0) begin
			for (int a = 0; a < 3; a++) begin
				it.pos[a] = $urandom;
				it.vel[a] = $urandom;
			end
			it.radius = 31'($urandom);
			it.dt = 20'($urandom);
		end else begin
			for (int a = 0; a < 3; a++) begin
				it.pos[a] = near_val(wall_cfg[a] + 64'd131072);
				it.vel[a] = near_val($urandom_range(0, 3) == 0 ? 64'd2147483647 : 64'd4194304);
			end
			it.radius = 31'($urandom_range(0, 262144));
			case ($urandom_range(0, 5))
				0: it.dt = '0;
				1: it.dt = 20'($urandom);
				default: it.dt = 20'($urandom_range(0, 65536));
			endcase
		end
		return it;
	endfunction

	function automatic step_in_t mk(longint px, longint py, longint pz, longint vx,
			longint vy, longint vz, longint r, longint dt);
		step_in_t it;
		it.pos[0] = 32'(px);
		it.pos[1] = 32'(py);
		it.pos[2] = 32'(pz);
		it.vel[0] = 32'(vx);
		it.vel[1] = 32'(vy);
		it.vel[2] = 32'(vz);
		it.radius = 31'(r);
		it.dt = 20'(dt);
		return it;
	endfunction

	task automatic add_row(step_in_t it, bit typed, step_res_t res);
		stim_row_t row;
		row.item = it;
		row.typed = typed;
		row.res = res;
		rows.push_back(row);
	endtask

	task automatic random_phase(int count);
		fast_send = ($urandom_range(0, 3) == 0);
		fast_recv = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < count; i++)
			offer_item(random_item(), 0, '0);
		drain();
	endtask

	initial begin
		step_res_t zero_res, wall_res, vmin_res;
		clk = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = REG_WALL_X;
		cfg_data = '0;
		s_tvalid = 0;
		s_tdata = '0;
		wall_cfg[0] = WALL_RST;
		wall_cfg[1] = WALL_RST;
		wall_cfg[2] = WALL_RST;
		gravity_cfg = GRAVITY_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		zero_res = '0;
		wall_res = '0;
		wall_res.mask = 3'b111;
		wall_res.zt = 1;
		vmin_res = wall_res;
		vmin_res.nv[0] = 32'h7fffffff;
		add_row(mk(0, 0, 0, 0, 0, 0, 0, 0), 1, zero_res);
		add_row(mk(0, 0, 0, 0, 0, 0, WALL_RST, 0), 1, wall_res);
		add_row(mk(0, 0, 0, -64'sd2147483648, 0, 0, WALL_RST, 0), 1, vmin_res);
		add_row(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 31'h7fffffff, 20'hfffff), 0, '0);
		add_row(mk(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
			-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 0, 20'hfffff), 0, '0);
		add_row(mk(-1, -1, -1, 1, 1, 1, 65536, 65536), 0, '0);
		add_row(mk(1310719, 1310719, 1310719, 65536, 65536, 65536, 0, 65536), 0, '0);
		add_row(mk(-1300000, -1300000, -1300000, -98304, -98304, -98304, 16384, 65536),
			0, '0);
		add_row(mk(0, 0, -1277952, 0, 0, -131072, 16384, 65536), 0, '0);
		add_row(mk(0, 0, 0, -1966080, -1966080, -1966080, 0, 65536), 0, '0);
		add_row(mk(100000, -100000, 5000, 70000, -70000, 300000, 1000, 20'hfffff), 0, '0);
		add_row(mk(65536, -65536, 131072, 65536, -65536, 0, 65536, 32768), 0, '0);
		add_row(mk(0, 0, 1310720, 0, 0, 5, 0, 0), 0, '0);
		foreach (rows[i])
			offer_item(rows[i].item, rows[i].typed, rows[i].res);
		drain();

		random_phase(250);

		fast_send = 1;
		fast_recv = 0;
		hold_req = 1;
		for (int i = 0; i < 120; i++)
			offer_item(random_item(), 0, '0);
		drain();

		write_reg(REG_WALL_X, 31'h7fffffff);
		write_reg(REG_WALL_Y, 31'h7fffffff);
		write_reg(REG_WALL_Z, 31'h7fffffff);
		write_reg(REG_GRAVITY, 31'h7fffffff);
		random_phase(150);

		write_reg(REG_WALL_X, 31'd0);
		write_reg(REG_WALL_Y, 31'd0);
		write_reg(REG_WALL_Z, 31'd0);
		write_reg(REG_GRAVITY, 31'd0);
		random_phase(150);

		for (int k = 0; k < 4; k++) begin
			write_reg(REG_WALL_X, 31'($urandom_range(0, 1 << (4 * k + 16))));
			write_reg(REG_WALL_Y, 31'($urandom));
			write_reg(REG_WALL_Z, 31'($urandom_range(0, 1 << (4 * k + 16))));
			write_reg(REG_GRAVITY, 31'($urandom));
			random_phase(130);
		end

		$display("Covered %0d items in and %0d results out over several wall and gravity",
			n_in, n_out);
		$display("settings; %0d results bounced, %0d with zero travel.", n_bounce, n_zero);
		if (errors == 0)
			$display("box_bounce_particle_step_top test passed");
		else
			$display("box_bounce_particle_step_top test failed");
		$finish;
	end

endmodule
